// File: src/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AT_ASSERT_NOW(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled during reset.
`define AT_ASSERT_NEXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!(resetn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// File: src/at_pkg.sv
package at_pkg;

    // Width of the internal saturating token counter
    localparam int COUNT_WIDTH = 16;
    // Width of the reported count field
    localparam int SHOWN_WIDTH = 16;

    // Parser mode codes
    localparam logic [2:0] MODE_GAP       = 3'd0;
    localparam logic [2:0] MODE_BARE      = 3'd1;
    localparam logic [2:0] MODE_BARE_ESC  = 3'd2;
    localparam logic [2:0] MODE_QUOTE     = 3'd3;
    localparam logic [2:0] MODE_QUOTE_ESC = 3'd4;

    // Special characters
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_END    = 8'h00;

    // One result word from the parser
    typedef struct packed {
        logic                   emit;
        logic [7:0]             data_byte;
        logic                   has_byte;
        logic                   token_end;
        logic                   string_done;
        logic                   unterminated_quote;
        logic [SHOWN_WIDTH-1:0] token_count;
    } at_result_t;

endpackage

// File: src/at_parse.sv
module at_parse
    import at_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] ch,
    output at_result_t result
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [2:0]             mode_reg;
    logic [2:0]             mode_next;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] count_bumped;
    logic [31:0]            count_wide;
    logic [2:0]             mode_in;
    logic                   blank;
    logic                   bump;
    logic                   clear;

    // Unused mode codes behave as between tokens
    assign mode_in = (mode_reg > MODE_QUOTE_ESC) ? MODE_GAP : mode_reg;
    assign blank   = (ch == 8'h20) || ((ch >= 8'h09) && (ch <= 8'h0D));

    // Next state and result for one character
    always_comb
    begin
        mode_next                 = mode_in;
        bump                      = 1'b0;
        clear                     = 1'b0;
        result.emit               = 1'b0;
        result.data_byte          = 8'h00;
        result.has_byte           = 1'b0;
        result.token_end          = 1'b0;
        result.string_done        = 1'b0;
        result.unterminated_quote = 1'b0;
        if (ch == CH_END)
        begin
            mode_next   = MODE_GAP;
            clear       = 1'b1;
            result.emit = 1'b1;
            if (mode_in == MODE_QUOTE || mode_in == MODE_QUOTE_ESC)
            begin
                result.unterminated_quote = 1'b1;
            end
            else if (mode_in == MODE_BARE || mode_in == MODE_BARE_ESC)
            begin
                bump               = 1'b1;
                result.token_end   = 1'b1;
                result.string_done = 1'b1;
            end
            else
            begin
                result.string_done = 1'b1;
            end
        end
        else
        begin
            case (mode_in)
                MODE_BARE:
                begin
                    if (blank)
                    begin
                        mode_next        = MODE_GAP;
                        bump             = 1'b1;
                        result.emit      = 1'b1;
                        result.token_end = 1'b1;
                    end
                    else if (ch == CH_BSLASH)
                    begin
                        mode_next = MODE_BARE_ESC;
                    end
                    else
                    begin
                        result.emit      = 1'b1;
                        result.has_byte  = 1'b1;
                        result.data_byte = ch;
                    end
                end
                MODE_BARE_ESC:
                begin
                    mode_next        = MODE_BARE;
                    result.emit      = 1'b1;
                    result.has_byte  = 1'b1;
                    result.data_byte = ch;
                end
                MODE_QUOTE:
                begin
                    if (ch == CH_QUOTE)
                    begin
                        mode_next        = MODE_GAP;
                        bump             = 1'b1;
                        result.emit      = 1'b1;
                        result.token_end = 1'b1;
                    end
                    else if (ch == CH_BSLASH)
                    begin
                        mode_next = MODE_QUOTE_ESC;
                    end
                    else
                    begin
                        result.emit      = 1'b1;
                        result.has_byte  = 1'b1;
                        result.data_byte = ch;
                    end
                end
                MODE_QUOTE_ESC:
                begin
                    mode_next        = MODE_QUOTE;
                    result.emit      = 1'b1;
                    result.has_byte  = 1'b1;
                    result.data_byte = ch;
                end
                default:
                begin
                    if (blank)
                    begin
                        mode_next = MODE_GAP;
                    end
                    else if (ch == CH_QUOTE)
                    begin
                        mode_next = MODE_QUOTE;
                    end
                    else if (ch == CH_BSLASH)
                    begin
                        mode_next = MODE_BARE_ESC;
                    end
                    else
                    begin
                        mode_next        = MODE_BARE;
                        result.emit      = 1'b1;
                        result.has_byte  = 1'b1;
                        result.data_byte = ch;
                    end
                end
            endcase
        end

        // Saturating count, including a token that completes now
        count_bumped = (bump && (count_reg != COUNT_MAX)) ? count_reg + 1'b1 : count_reg;
        count_wide   = 32'(count_bumped);

        // Reported count clamps to the field width
        result.token_count = (count_wide > 32'h0000_FFFF) ? 16'hFFFF : count_wide[15:0];
    end

    assign count_next = clear ? '0 : count_bumped;

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_GAP;
            count_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

endmodule

// File: src/argument_tokenizer.sv
// Shell-style argument tokenizer.
// Input stream s_axis: one character per word in tdata[7:0]; a zero byte
// ends the string. Output stream m_axis: at most one word per character.
// Output tdata carries the token byte and the running token count, tlast
// flags the end of a token, tuser carries has_byte, string_done and
// unterminated_quote. Whitespace between tokens, an opening quote and an
// escaping backslash give no output word.
// Path: a character passes the input register, then the parse step into
// the output register.
// Throughput: one character per cycle while the output register can take a result.
// Stall: while m_axis_tready is low the output word holds; the input
// register still drains characters that give no word, and s_axis_tready
// drops only once a pending character needs the full output register.
// Reset: both registers empty, parser between tokens, count zero. After
// each end of string the parser returns to that same state by itself.
module argument_tokenizer
    import at_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] data_byte, [23:8] token_count
    output logic        m_axis_tlast,   // token_end
    output logic [2:0]  m_axis_tuser    // [0] has_byte, [1] string_done, [2] unterminated_quote
);

    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       out_valid_reg;
    at_result_t out_reg;
    at_result_t result;
    logic       advance;
    logic       out_free;

    // The input word moves on when the output register can take a result or none is due
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (out_free || !result.emit);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            ch_reg <= s_axis_tdata;
        end
    end

    at_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .ch     (ch_reg),
        .result (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= advance && result.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && advance && result.emit)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.token_count, out_reg.data_byte};
    assign m_axis_tlast  = out_reg.token_end;
    assign m_axis_tuser  = {out_reg.unterminated_quote, out_reg.string_done, out_reg.has_byte};

endmodule

// File: src/at_checker.sv
`include "assert_macros.svh"

module at_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [2:0]  m_axis_tuser
);

    logic stalled;
    assign stalled = m_axis_tvalid && !m_axis_tready;

    // A stalled word stays offered
    `AT_ASSERT_NEXT(a_hold_valid, clk, rst_n, stalled, m_axis_tvalid)
    // A stalled word keeps its payload
    `AT_ASSERT_NEXT(a_hold_data, clk, rst_n, stalled, $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    // A byte word carries no end or status flag
    `AT_ASSERT_NOW(a_byte_alone, clk, rst_n, m_axis_tvalid && m_axis_tuser[0], !m_axis_tlast && !m_axis_tuser[1] && !m_axis_tuser[2])
    // An open quote at end of string neither succeeds nor closes a token
    `AT_ASSERT_NOW(a_unterm_alone, clk, rst_n, m_axis_tvalid && m_axis_tuser[2], !m_axis_tlast && !m_axis_tuser[1] && m_axis_tdata[7:0] == 8'h00)

endmodule

bind argument_tokenizer at_checker u_at_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import at_pkg::*;

    // One result word as the tokenizer reports it
    typedef struct packed {
        logic [7:0]             data_byte;
        logic                   has_byte;
        logic                   token_end;
        logic                   string_done;
        logic                   unterminated_quote;
        logic [SHOWN_WIDTH-1:0] token_count;
    } tok_result_t;

    // One character to send; typed rows carry their own expected word
    typedef struct packed {
        logic [7:0]  ch;
        logic        typed;
        logic        rush;
        tok_result_t res;
    } char_row_t;

    localparam int DIRECTED_ROWS = 27;
    localparam int RANDOM_CHARS  = 1250;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;     // [7:0] data_byte, [23:8] token_count
    logic        m_axis_tlast;     // token_end
    logic [2:0]  m_axis_tuser;     // [0] has_byte, [1] string_done, [2] unterminated_quote

    argument_tokenizer uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Directed characters; expected words typed in for the obvious ones
    char_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'h00, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0, 16'd0}},  // end right after reset
        '{8'hFF, 1'b1, 1'b0, '{8'hFF, 1'b1, 1'b0, 1'b0, 1'b0, 16'd0}},  // top byte value
        '{8'h20, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b1, 1'b0, 1'b0, 16'd1}},  // space ends the token
        '{CH_QUOTE,  1'b0, 1'b0, '0},   // open quote, silent
        '{8'h20,     1'b0, 1'b0, '0},   // space kept inside quotes
        '{CH_BSLASH, 1'b0, 1'b0, '0},   // escape inside quotes
        '{CH_QUOTE,  1'b0, 1'b0, '0},   // escaped quote is data
        '{CH_QUOTE,  1'b0, 1'b0, '0},   // closing quote
        '{8'h41,     1'b0, 1'b0, '0},   // new token right after the close
        '{CH_QUOTE,  1'b0, 1'b0, '0},   // quote in mid token is data
        '{8'h09,     1'b0, 1'b0, '0},   // tab ends the token
        '{8'h0D,     1'b0, 1'b0, '0},
        '{8'h0A,     1'b0, 1'b0, '0},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_END,    1'b0, 1'b0, '0},   // trailing backslash, unquoted
        '{CH_QUOTE,  1'b0, 1'b0, '0},
        '{8'h01,     1'b0, 1'b0, '0},
        '{CH_END, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0}}, // open quote at end
        '{CH_QUOTE,  1'b0, 1'b0, '0},
        '{CH_BSLASH, 1'b0, 1'b0, '0},
        '{CH_END, 1'b1, 1'b0, '{8'h00, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0}}, // trailing backslash, quoted
        '{CH_QUOTE,  1'b0, 1'b0, '0},
        '{CH_QUOTE,  1'b0, 1'b0, '0},   // empty quoted token
        '{8'h0B,     1'b0, 1'b0, '0},
        '{8'h80,     1'b0, 1'b0, '0},
        '{8'h0C,     1'b0, 1'b0, '0},
        '{CH_END,    1'b0, 1'b0, '0}
    };

    char_row_t   char_q [$];
    tok_result_t expected_words [$];

    // Tokenizer state as the predictor sees it
    logic [2:0]             cur_mode = MODE_GAP;
    logic [COUNT_WIDTH-1:0] tokens_done = '0;

    int  mismatches = 0;
    int  words_checked = 0;
    int  tokens_ended = 0;
    int  strings_ended = 0;
    int  sent = 0;
    int  taken = 0;
    logic fast_phase = 1'b0;

    function automatic bit is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic tok_result_t make_word(logic [7:0] b, bit has, bit fin, bit done,
                                              bit open_q);
        tok_result_t     w;
        longint unsigned wide;
        longint unsigned top;
        wide = longint'(tokens_done);
        top = (64'd1 << SHOWN_WIDTH) - 1;
        w.data_byte = has ? b : 8'h00;
        w.has_byte = has;
        w.token_end = fin;
        w.string_done = done;
        w.unterminated_quote = open_q;
        w.token_count = (wide > top) ? {SHOWN_WIDTH{1'b1}} : wide[SHOWN_WIDTH-1:0];
        return w;
    endfunction

    function automatic void count_token();
        if (tokens_done != {COUNT_WIDTH{1'b1}})
            tokens_done = tokens_done + 1'b1;
    endfunction

    // Advance the predicted parser by one character; returns 1 if a word is due
    function automatic bit tokenize_char(logic [7:0] c, output tok_result_t w);
        logic [2:0] m;
        m = (cur_mode > MODE_QUOTE_ESC) ? MODE_GAP : cur_mode;
        w = '0;
        if (c == CH_END) begin
            if (m == MODE_QUOTE || m == MODE_QUOTE_ESC)
                w = make_word(8'h00, 0, 0, 0, 1);
            else if (m == MODE_BARE || m == MODE_BARE_ESC) begin
                count_token();
                w = make_word(8'h00, 0, 1, 1, 0);
            end
            else
                w = make_word(8'h00, 0, 0, 1, 0);
            cur_mode = MODE_GAP;
            tokens_done = '0;
            return 1;
        end
        case (m)
            MODE_BARE:
            begin
                if (is_space(c)) begin
                    cur_mode = MODE_GAP;
                    count_token();
                    w = make_word(8'h00, 0, 1, 0, 0);
                    return 1;
                end
                if (c == CH_BSLASH) begin
                    cur_mode = MODE_BARE_ESC;
                    return 0;
                end
                w = make_word(c, 1, 0, 0, 0);
                return 1;
            end
            MODE_BARE_ESC:
            begin
                cur_mode = MODE_BARE;
                w = make_word(c, 1, 0, 0, 0);
                return 1;
            end
            MODE_QUOTE:
            begin
                if (c == CH_QUOTE) begin
                    cur_mode = MODE_GAP;
                    count_token();
                    w = make_word(8'h00, 0, 1, 0, 0);
                    return 1;
                end
                if (c == CH_BSLASH) begin
                    cur_mode = MODE_QUOTE_ESC;
                    return 0;
                end
                w = make_word(c, 1, 0, 0, 0);
                return 1;
            end
            MODE_QUOTE_ESC:
            begin
                cur_mode = MODE_QUOTE;
                w = make_word(c, 1, 0, 0, 0);
                return 1;
            end
            default:
            begin
                if (is_space(c)) begin
                    cur_mode = MODE_GAP;
                    return 0;
                end
                if (c == CH_QUOTE) begin
                    cur_mode = MODE_QUOTE;
                    return 0;
                end
                if (c == CH_BSLASH) begin
                    cur_mode = MODE_BARE_ESC;
                    return 0;
                end
                cur_mode = MODE_BARE;
                w = make_word(c, 1, 0, 0, 0);
                return 1;
            end
        endcase
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] space_char();
        logic [7:0] b;
        b = 8'($urandom_range(8, 13));
        if (b == 8'h08)
            b = 8'h20;
        return b;
    endfunction

    // Ordinary token byte: no blank, quote, backslash or terminator
    function automatic logic [7:0] plain_char();
        logic [7:0] b;
        b = 8'($urandom_range(1, 255));
        if (is_space(b) || b == CH_QUOTE || b == CH_BSLASH)
            b = 8'h61 + 8'($urandom_range(0, 25));
        return b;
    endfunction

    task automatic push_char(logic [7:0] c, logic rush = 1'b0);
        char_q.push_back(char_row_t'{c, 1'b0, rush, tok_result_t'('0)});
    endtask

    // One random string: mostly well-formed tokens, some noise
    task automatic add_string();
        int  ntok;
        int  len;
        int  k;
        bit  quoted;
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 12);
            repeat (len)
            begin
                k = $urandom_range(0, 9);
                case (k)
                    0: push_char(CH_QUOTE);
                    1: push_char(CH_BSLASH);
                    2: push_char(space_char());
                    default: push_char(8'($urandom_range(1, 255)));
                endcase
            end
            push_char(CH_END);
            return;
        end
        ntok = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            push_char(space_char());
        for (int t = 0; t < ntok; t++) begin
            quoted = ($urandom_range(0, 2) == 0);
            len = $urandom_range(quoted ? 0 : 1, 6);
            if (quoted)
                push_char(CH_QUOTE);
            for (int i = 0; i < len; i++) begin
                k = $urandom_range(0, 9);
                if (k == 0) begin
                    push_char(CH_BSLASH);
                    push_char(8'($urandom_range(1, 255)));
                end
                else if (k == 1 && (quoted || i > 0))
                    push_char(quoted ? space_char() : CH_QUOTE);
                else
                    push_char(plain_char());
            end
            if (quoted) begin
                // now and then leave the quote open
                if ($urandom_range(0, 14) == 0)
                    break;
                push_char(CH_QUOTE);
                if ($urandom_range(0, 2) != 0)
                    push_char(space_char());
            end
            else if ($urandom_range(0, 3) != 0)
                push_char(space_char());
        end
        if ($urandom_range(0, 9) == 0)
            push_char(CH_BSLASH);
        push_char(CH_END);
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Clock and reset
    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Run limit
    initial
    begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Build the stimulus, drive it, then drain and report
    initial
    begin
        int gap;
        int burst;
        burst = 0;
        foreach (directed_rows[i])
            char_q.push_back(directed_rows[i]);
        while (char_q.size() < DIRECTED_ROWS + RANDOM_CHARS)
            add_string();

        while (!rst_n)
            @(posedge clk);
        while (sent < char_q.size()) begin
            if (char_q[sent].rush)
                gap = 0;
            else if (burst > 0) begin
                gap = 0;
                burst--;
            end
            else if ($urandom_range(0, 49) == 0) begin
                gap = 0;
                burst = 60;
            end
            else
                gap = pick_gap();
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= char_q[sent].ch;
            fast_phase <= char_q[sent].rush;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            sent++;
        end
        s_axis_tvalid <= 1'b0;
        fast_phase <= 1'b0;

        // let the last character reach the predictor, then drain
        repeat (4) @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("Sent %0d characters in %0d strings; checked %0d words, %0d token ends.",
                 taken, strings_ended, words_checked, tokens_ended);
        $display("Included quotes, escapes, open quotes, trailing backslashes and a long stall.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Output ready: random holds, one long stall once the pipe is busy
    initial
    begin
        int  hold;
        bit  squeezed;
        squeezed = 0;
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (!squeezed && words_checked >= 150) begin
                squeezed = 1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
            end
            else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                hold = fast_phase ? 0 : pick_gap();
                if (hold > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (hold) @(posedge clk);
                end
            end
        end
    end

    // Input side: predict the word for each accepted character
    always @(posedge clk)
    begin
        tok_result_t w;
        bit          due;
        if (rst_n && s_axis_tvalid && s_axis_tready) begin
            due = tokenize_char(s_axis_tdata, w);
            if (char_q[taken].typed) begin
                w = char_q[taken].res;
                due = 1;
            end
            if (due)
                expected_words.push_back(w);
            if (s_axis_tdata == CH_END)
                strings_ended++;
            taken++;
        end
    end

    // Output side: compare each accepted word with the oldest expectation
    always @(posedge clk)
    begin
        tok_result_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected output word: tdata 0x%0h tlast %0b tuser 0x%0h",
                       m_axis_tdata, m_axis_tlast, m_axis_tuser);
                mismatches++;
            end
            else begin
                w = expected_words.pop_front();
                check_field("data_byte", w.data_byte, m_axis_tdata[7:0]);
                check_field("token_count", w.token_count, m_axis_tdata[23:8]);
                check_field("token_end", w.token_end, m_axis_tlast);
                check_field("has_byte", w.has_byte, m_axis_tuser[0]);
                check_field("string_done", w.string_done, m_axis_tuser[1]);
                check_field("unterminated_quote", w.unterminated_quote, m_axis_tuser[2]);
                if (w.token_end)
                    tokens_ended++;
                words_checked++;
            end
        end
    end

endmodule
